// File: sv/dtps_pkg.sv
// ----------------------------------------------------------------------------
// dtps_pkg
// shared types, constants and helpers for the drum trigger peak scanner
// ----------------------------------------------------------------------------
package dtps_pkg;

  localparam int unsigned CHANNELS  = 5;
  localparam int unsigned CH_W      = 3;
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned WINDOW_W  = 16;
  localparam int unsigned VEL_W     = 7;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;

  localparam logic [SAMPLE_W-1:0] VELOCITY_MAX  = SAMPLE_W'(127);
  localparam logic [WINDOW_W-1:0] WINDOW_RESET  = WINDOW_W'(120);

  // register map, index = paddr / 4
  typedef enum logic [2:0] {
    REG_WINDOW = 3'd0,
    REG_THR0   = 3'd1,
    REG_THR1   = 3'd2,
    REG_THR2   = 3'd3,
    REG_THR3   = 3'd4,
    REG_THR4   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [WINDOW_W-1:0]                window_length;
    logic [CHANNELS-1:0][SAMPLE_W-1:0]  threshold;
  } cfg_t;

  typedef struct packed {
    logic                note_valid;
    logic [CH_W-1:0]     note_number;
    logic [VEL_W-1:0]    velocity;
    logic [CH_W-1:0]     next_channel;
  } note_t;

  function automatic logic [CH_W-1:0] adv_channel(input logic [CH_W-1:0] ch);
    logic [CH_W-1:0] nxt;
    if (ch >= CH_W'(CHANNELS - 1)) begin
      nxt = '0;
    end else begin
      nxt = ch + CH_W'(1);
    end
    return nxt;
  endfunction

  function automatic logic [SAMPLE_W-1:0] thr_reset(input int unsigned ch);
    logic [SAMPLE_W-1:0] v;
    unique case (ch)
      0:       v = SAMPLE_W'(10);
      1:       v = SAMPLE_W'(10);
      2:       v = SAMPLE_W'(20);
      3:       v = SAMPLE_W'(32);
      default: v = SAMPLE_W'(20);
    endcase
    return v;
  endfunction

endpackage

// File: sv/dtps_regs.sv
// ----------------------------------------------------------------------------
// dtps_regs
// apb register file: window length and per-channel trigger thresholds
// ----------------------------------------------------------------------------
module dtps_regs
  import dtps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_length <= WINDOW_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        cfg.threshold[i] <= thr_reset(i);
      end
    end else if (wr_en) begin
      unique case (idx)
        REG_WINDOW: cfg.window_length <= pwdata[WINDOW_W-1:0];
        REG_THR0:   cfg.threshold[0]  <= pwdata[SAMPLE_W-1:0];
        REG_THR1:   cfg.threshold[1]  <= pwdata[SAMPLE_W-1:0];
        REG_THR2:   cfg.threshold[2]  <= pwdata[SAMPLE_W-1:0];
        REG_THR3:   cfg.threshold[3]  <= pwdata[SAMPLE_W-1:0];
        REG_THR4:   cfg.threshold[4]  <= pwdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_WINDOW: prdata = DATA_W'(cfg.window_length);
      REG_THR0:   prdata = DATA_W'(cfg.threshold[0]);
      REG_THR1:   prdata = DATA_W'(cfg.threshold[1]);
      REG_THR2:   prdata = DATA_W'(cfg.threshold[2]);
      REG_THR3:   prdata = DATA_W'(cfg.threshold[3]);
      REG_THR4:   prdata = DATA_W'(cfg.threshold[4]);
      default:    prdata = '0;
    endcase
  end

endmodule

// File: sv/dtps_core.sv
// ----------------------------------------------------------------------------
// dtps_core
// scan state and per-sample trigger, peak and window logic
// ----------------------------------------------------------------------------
module dtps_core
  import dtps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [SAMPLE_W-1:0] sample,
  input  cfg_t                cfg,
  output note_t               note
);

  logic [CH_W-1:0]     current_channel, current_channel_next;
  logic                in_hit, in_hit_next;
  logic [SAMPLE_W-1:0] peak_value, peak_value_next;
  logic [WINDOW_W-1:0] window_count, window_count_next;
  logic [SAMPLE_W-1:0] thr;

  assign thr = cfg.threshold[current_channel];

  always_comb begin
    current_channel_next = current_channel;
    in_hit_next          = in_hit;
    peak_value_next      = peak_value;
    window_count_next    = window_count;
    note                 = '0;
    if (!in_hit) begin
      if (sample > thr) begin
        peak_value_next   = sample;
        window_count_next = '0;
        in_hit_next       = 1'b1;
      end else begin
        current_channel_next = adv_channel(current_channel);
      end
    end else begin
      if (sample > peak_value) begin
        peak_value_next = sample;
      end
      if (window_count < cfg.window_length) begin
        window_count_next = window_count + WINDOW_W'(1);
      end else begin
        note.note_valid      = 1'b1;
        note.note_number     = current_channel;
        note.velocity        = (peak_value_next > VELOCITY_MAX) ?
                               VELOCITY_MAX[VEL_W-1:0] : peak_value_next[VEL_W-1:0];
        window_count_next    = '0;
        in_hit_next          = 1'b0;
        current_channel_next = adv_channel(current_channel);
      end
    end
    note.next_channel = current_channel_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_channel <= '0;
      in_hit          <= 1'b0;
      peak_value      <= '0;
      window_count    <= '0;
    end else if (push) begin
      current_channel <= current_channel_next;
      in_hit          <= in_hit_next;
      peak_value      <= peak_value_next;
      window_count    <= window_count_next;
    end
  end

endmodule

// File: sv/dtps_outbuf.sv
// ----------------------------------------------------------------------------
// dtps_outbuf
// result register with a skid entry, ready toward the input is registered
// ----------------------------------------------------------------------------
module dtps_outbuf
  import dtps_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  note_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output note_t out_data
);

  logic  skid_valid;
  note_t skid_data;
  logic  push;
  logic  head_free;

  assign in_ready  = ~skid_valid;
  assign push      = in_valid & in_ready;
  assign head_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (head_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= in_data;
      end
    end else if (push) begin
      skid_data <= in_data;
    end
  end

endmodule

// File: sv/drum_trigger_peak_scanner_unit.sv
// ----------------------------------------------------------------------------
// drum_trigger_peak_scanner_unit
// round-robin piezo trigger scanner emitting note-on events with peak velocity
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------
//  sample   | sample_valid / sample_ready | sample[9:0]
//  result   | result_valid / result_ready | note_valid, note_number[2:0],
//           |                             | velocity[6:0], next_channel[2:0]
//  config   | apb psel/penable/pwrite     | paddr[4:0], pwdata, prdata
//
//  one sample per cycle while sample_ready is high: each transfer updates the
//  scan state and registers its result into the output slots at its clock edge
//  every sample transfer yields exactly one result transfer
//  a result register plus one skid entry sit at the output; sample_ready
//  drops only when both are full, so it is a register and falls the cycle
//  after a result stall catches a new sample
//  synchronous reset restores register defaults and idle scan on channel 0
// ----------------------------------------------------------------------------
module drum_trigger_peak_scanner_unit
  import dtps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // sample channel
  input  logic                sample_valid,
  output logic                sample_ready,
  input  logic [SAMPLE_W-1:0] sample,
  // result channel
  output logic                result_valid,
  input  logic                result_ready,
  output logic                note_valid,
  output logic [CH_W-1:0]     note_number,
  output logic [VEL_W-1:0]    velocity,
  output logic [CH_W-1:0]     next_channel,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  cfg_t  cfg;
  note_t core_note;
  note_t res;
  logic  push;

  // sample transfer advances the scan state
  assign push = sample_valid & sample_ready;

  // window length and thresholds
  dtps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // trigger compare, peak tracking, window count and channel advance
  dtps_core u_core (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .sample (sample),
    .cfg    (cfg),
    .note   (core_note)
  );

  // result register with skid entry
  dtps_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_valid),
    .in_ready  (sample_ready),
    .in_data   (core_note),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (res)
  );

  assign note_valid   = res.note_valid;
  assign note_number  = res.note_number;
  assign velocity     = res.velocity;
  assign next_channel = res.next_channel;

endmodule

// File: sv/dtps_checker.sv
// ----------------------------------------------------------------------------
// dtps_checker
// port-level checks on the scanner's result channel
// ----------------------------------------------------------------------------
module dtps_checker
  import dtps_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                sample_ready,
  input logic                result_valid,
  input logic                result_ready,
  input logic                note_valid,
  input logic [CH_W-1:0]     note_number,
  input logic [VEL_W-1:0]    velocity,
  input logic [CH_W-1:0]     next_channel
);

  // stalled result stays valid and holds note_valid, velocity and next_channel
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(note_valid) && $stable(velocity) && $stable(next_channel))
    else $error("result changed while stalled");

  // no note means zero note fields
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && !note_valid |-> note_number == '0 && velocity == '0)
    else $error("note fields set without note");

  // next channel stays in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> next_channel < CH_W'(CHANNELS))
    else $error("next channel out of range");

  // a note always moves the scan to the following channel
  a_advance: assert property (@(posedge clk) disable iff (rst)
    result_valid && note_valid |-> next_channel == adv_channel(note_number))
    else $error("scan did not advance after note");

  // both output slots empty right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> sample_ready && !result_valid)
    else $error("output not empty after reset");

endmodule

bind drum_trigger_peak_scanner_unit dtps_checker u_dtps_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_ready (sample_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .note_valid   (note_valid),
  .note_number  (note_number),
  .velocity     (velocity),
  .next_channel (next_channel)
);
